@@ hw/rtl/pph_pkg.sv @@
package pph_pkg;

    localparam int unsigned TICK_W = 16;
    localparam int unsigned BYTE_W = 8;

    typedef enum logic [2:0] {
        ACT_TICK       = 3'd0,
        ACT_WRITE_BYTE = 3'd1,
        ACT_WRITE_BIT  = 3'd2,
        ACT_STROBE     = 3'd3,
        ACT_ONLINE     = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_TO_ACK    = 2'd1,
        PH_TO_UNBUSY = 2'd2,
        PH_TO_ACKHI  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        REG_BUSY_TO_ACK_LOW   = 2'd0,
        REG_ACK_LOW_TO_UNBUSY = 2'd1,
        REG_UNBUSY_TO_ACK_HI  = 2'd2
    } reg_index_t;

    localparam logic [TICK_W-1:0] RST_BUSY_TO_ACK_LOW   = 16'd10;
    localparam logic [TICK_W-1:0] RST_ACK_LOW_TO_UNBUSY = 16'd7;
    localparam logic [TICK_W-1:0] RST_UNBUSY_TO_ACK_HI  = 16'd5;

    typedef struct packed {
        logic [TICK_W-1:0] busy_to_ack_low;
        logic [TICK_W-1:0] ack_low_to_unbusy;
        logic [TICK_W-1:0] unbusy_to_ack_hi;
    } timing_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [BYTE_W-1:0] byte_value;
        logic [2:0]        bit_index;
        logic              level;
    } item_t;

    typedef struct packed {
        logic              ack_level;
        logic              busy_level;
        logic              paper_end_level;
        logic              fault_level;
        logic [BYTE_W-1:0] data_latch;
        logic              print_valid;
        logic [BYTE_W-1:0] print_byte;
    } result_t;

endpackage

@@ hw/rtl/pph_cfg_regs.sv @@
module pph_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output pph_pkg::timing_t    timing
);

    pph_pkg::timing_t timing_reg;
    pph_pkg::timing_t timing_next;

    assign cfg_ready = 1'b1;
    assign timing    = timing_reg;

    always_comb
    begin
        timing_next = timing_reg;
        if (cfg_valid)
        begin
            unique case (pph_pkg::reg_index_t'(cfg_index))
                pph_pkg::REG_BUSY_TO_ACK_LOW:   timing_next.busy_to_ack_low   = cfg_data;
                pph_pkg::REG_ACK_LOW_TO_UNBUSY: timing_next.ack_low_to_unbusy = cfg_data;
                pph_pkg::REG_UNBUSY_TO_ACK_HI:  timing_next.unbusy_to_ack_hi  = cfg_data;
                default: ; // Indexes past the register list are dropped.
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.busy_to_ack_low   <= pph_pkg::RST_BUSY_TO_ACK_LOW;
            timing_reg.ack_low_to_unbusy <= pph_pkg::RST_ACK_LOW_TO_UNBUSY;
            timing_reg.unbusy_to_ack_hi  <= pph_pkg::RST_UNBUSY_TO_ACK_HI;
        end
        else
        begin
            timing_reg <= timing_next;
        end
    end

endmodule

@@ hw/rtl/pph_in_stage.sv @@
module pph_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  pph_pkg::item_t in_item,
    output logic           item_valid,
    output pph_pkg::item_t item,
    input  logic           item_take
);

    logic           valid_reg;
    logic           valid_next;
    pph_pkg::item_t item_reg;

    // The held transaction leaves whenever the next stage takes it, so the
    // slot frees up in the same cycle and a new item can enter.
    assign in_stall   = valid_reg && !item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (!in_stall)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ hw/rtl/pph_core.sv @@
module pph_core (
    input  logic             clk,
    input  logic             rst_n,
    input  pph_pkg::timing_t timing,
    input  logic             item_valid,
    input  pph_pkg::item_t   item,
    output logic             item_take,
    output logic             out_valid,
    input  logic             out_stall,
    output pph_pkg::result_t result
);

    pph_pkg::phase_t   phase_reg, phase_next;
    logic [15:0]       cnt_reg, cnt_next;
    logic [7:0]        data_reg, data_next;
    logic              strobe_reg, strobe_next;
    logic              busy_reg, busy_next;
    logic              ack_reg, ack_next;
    logic              paper_end_reg, paper_end_next;
    logic              fault_reg, fault_next;
    logic              out_valid_reg, out_valid_next;
    pph_pkg::result_t  result_reg, result_next;

    pph_pkg::action_t  act;
    logic              step;
    logic              tick_step;
    logic [15:0]       cnt_dec;
    logic              phase_end;
    logic              start;
    logic              printed;

    assign item_take = !out_valid_reg || !out_stall;
    assign step      = item_valid && item_take;
    assign act       = pph_pkg::action_t'(item.action);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // A countdown already at zero stays there, so a zero delay ends the
    // phase on the first tick just like a delay of one.
    assign tick_step = step && (act == pph_pkg::ACT_TICK) && (phase_reg != pph_pkg::PH_IDLE);
    assign cnt_dec   = (cnt_reg != 16'd0) ? (cnt_reg - 16'd1) : cnt_reg;
    assign phase_end = tick_step && (cnt_dec == 16'd0);
    assign start     = step && (act == pph_pkg::ACT_STROBE) && strobe_reg && !item.level
                       && !busy_reg && (phase_reg == pph_pkg::PH_IDLE);
    assign printed   = phase_end && (phase_reg == pph_pkg::PH_TO_ACK);

    // Handshake phase and countdown.
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        if (start)
        begin
            phase_next = pph_pkg::PH_TO_ACK;
            cnt_next   = timing.busy_to_ack_low;
        end
        else if (tick_step)
        begin
            cnt_next = cnt_dec;
            if (phase_end)
            begin
                unique case (phase_reg)
                    pph_pkg::PH_TO_ACK:
                    begin
                        phase_next = pph_pkg::PH_TO_UNBUSY;
                        cnt_next   = timing.ack_low_to_unbusy;
                    end
                    pph_pkg::PH_TO_UNBUSY:
                    begin
                        phase_next = pph_pkg::PH_TO_ACKHI;
                        cnt_next   = timing.unbusy_to_ack_hi;
                    end
                    pph_pkg::PH_TO_ACKHI:
                    begin
                        phase_next = pph_pkg::PH_IDLE;
                        cnt_next   = 16'd0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Line flags, data register and the result of this transaction.
    always_comb
    begin
        data_next      = data_reg;
        strobe_next    = strobe_reg;
        busy_next      = busy_reg;
        ack_next       = ack_reg;
        paper_end_next = paper_end_reg;
        fault_next     = fault_reg;
        if (step)
        begin
            unique case (act)
                pph_pkg::ACT_TICK:
                begin
                    if (phase_end)
                    begin
                        unique case (phase_reg)
                            pph_pkg::PH_TO_ACK:    ack_next  = 1'b0;
                            pph_pkg::PH_TO_UNBUSY: busy_next = 1'b0;
                            pph_pkg::PH_TO_ACKHI:  ack_next  = 1'b1;
                            default: ;
                        endcase
                    end
                end
                pph_pkg::ACT_WRITE_BYTE: data_next = item.byte_value;
                pph_pkg::ACT_WRITE_BIT:  data_next[item.bit_index] = item.level;
                pph_pkg::ACT_STROBE:
                begin
                    strobe_next = item.level;
                    if (start)
                    begin
                        busy_next = 1'b1;
                    end
                end
                pph_pkg::ACT_ONLINE:
                begin
                    paper_end_next = item.level;
                    fault_next     = item.level;
                    busy_next      = !item.level;
                end
                default: ; // Unused action codes only report the state.
            endcase
        end

        result_next.ack_level       = ack_next;
        result_next.busy_level      = busy_next;
        result_next.paper_end_level = paper_end_next;
        result_next.fault_level     = fault_next;
        result_next.data_latch      = data_next;
        result_next.print_valid     = printed;
        result_next.print_byte      = printed ? data_reg : 8'd0;

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pph_pkg::PH_IDLE;
            cnt_reg       <= 16'd0;
            data_reg      <= 8'd0;
            strobe_reg    <= 1'b1;
            busy_reg      <= 1'b1;
            ack_reg       <= 1'b1;
            paper_end_reg <= 1'b0;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            data_reg      <= data_next;
            strobe_reg    <= strobe_next;
            busy_reg      <= busy_next;
            ack_reg       <= ack_next;
            paper_end_reg <= paper_end_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

endmodule

@@ hw/rtl/parallel_printer_handshake.sv @@
// Channel   Handshake           Payload
// -------   -----------------   ------------------------------------------------
// input     in_valid/in_stall   action, byte_value, bit_index, level
// result    out_valid/out_stall ack_level, busy_level, paper_end_level,
//                               fault_level, data_latch, print_valid, print_byte
// config    cfg_valid/cfg_ready cfg_index, cfg_data
//
// One transaction per cycle while out_stall is low; a taken input waits in the input
// register until the core takes it and loads the result register. Reset brings ack,
// busy and strobe high, timings to 10, 7, 5 and other state low; the item and
// result registers are not reset. A stalled result holds the result register and
// backs up through the input register. cfg_ready is always high.
module parallel_printer_handshake (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [7:0]  byte_value,
    input  logic [2:0]  bit_index,
    input  logic        level,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        ack_level,
    output logic        busy_level,
    output logic        paper_end_level,
    output logic        fault_level,
    output logic [7:0]  data_latch,
    output logic        print_valid,
    output logic [7:0]  print_byte,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    pph_pkg::timing_t timing;
    pph_pkg::item_t   in_item;
    pph_pkg::item_t   item;
    logic             item_valid;
    logic             item_take;
    pph_pkg::result_t result;

    assign in_item.action     = action;
    assign in_item.byte_value = byte_value;
    assign in_item.bit_index  = bit_index;
    assign in_item.level      = level;

    pph_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing    (timing)
    );

    pph_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    pph_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .timing     (timing),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result)
    );

    assign ack_level       = result.ack_level;
    assign busy_level      = result.busy_level;
    assign paper_end_level = result.paper_end_level;
    assign fault_level     = result.fault_level;
    assign data_latch      = result.data_latch;
    assign print_valid     = result.print_valid;
    assign print_byte      = result.print_byte;

endmodule
